// ----- sv/rmfb_pkg.sv -----
package rmfb_pkg;

	localparam int PANEL_COLS = 296;
	localparam int PANEL_ROWS = 128;
	localparam int STRIDE = (PANEL_ROWS + 7) / 8;
	localparam int STORE_BYTES = PANEL_COLS * STRIDE;

	localparam int OP_W = 2;
	localparam int COL_W = 9;
	localparam int ROW_W = 7;
	localparam int COLOR_W = 16;
	localparam int ADDR_W = 13;
	localparam int BYTE_W = 8;
	localparam int LUMA_W = 16;

	localparam logic [LUMA_W-1:0] THRESHOLD_RESET = 16'd32768;

	// luma weights, channels taken at 8 bits
	localparam int W_RED = 77;
	localparam int W_GREEN = 150;
	localparam int W_BLUE = 29;

	localparam logic [BYTE_W-1:0] BIT_MSB = 8'h80;
	localparam logic [BYTE_W-1:0] BYTE_WHITE = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_BLACK = 8'h00;

	typedef enum logic [OP_W-1:0] {
		OP_FILL      = 2'd0,
		OP_PLOT_MONO = 2'd1,
		OP_PLOT_RGB  = 2'd2,
		OP_READ      = 2'd3
	} op_t;

endpackage

// ----- sv/rmfb_luma.sv -----
module rmfb_luma (
	input  logic [rmfb_pkg::COLOR_W-1:0] pixel_color,
	output logic [rmfb_pkg::LUMA_W-1:0]  luma
);
	import rmfb_pkg::*;

	logic [7:0]        r8;
	logic [7:0]        g8;
	logic [7:0]        b8;
	logic [LUMA_W-1:0] sum;

	// widen each channel to 8 bits by shifting left
	assign r8 = {pixel_color[15:11], 3'b000};
	assign g8 = {pixel_color[10:5], 2'b00};
	assign b8 = {pixel_color[4:0], 3'b000};

	// the weighted sum peaks at 64088, so 16 bits hold every term and the total
	assign sum = LUMA_W'(r8) * LUMA_W'(W_RED)
		+ LUMA_W'(g8) * LUMA_W'(W_GREEN)
		+ LUMA_W'(b8) * LUMA_W'(W_BLUE);

	assign luma = sum;

endmodule

// ----- sv/rotated_mono_frame_builder.sv -----
// Rotated monochrome frame builder. Holds a 1-bit panel frame store (4736 bytes, MSB first,
// 0 bit = black) in one synchronous RAM; a landscape canvas pixel (col, row) lands in byte
// col*16 + row/8. Requests enter on in_valid/in_stall and read results leave through an
// output register on out_valid/out_stall. A plot reads the RAM, then modifies and writes back;
// a byte read reads the RAM, then loads the output register. A fill writes one byte per
// cycle and so holds in_stall until all 4736 bytes are written; the same sweep runs after
// reset to whiten the store, during which no request is taken. The luma threshold may be
// written at any time through cfg_wr_en/cfg_wr_data.
module rotated_mono_frame_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rmfb_pkg::LUMA_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rmfb_pkg::OP_W-1:0]     operation,
	input  logic [rmfb_pkg::COL_W-1:0]    col,
	input  logic [rmfb_pkg::ROW_W-1:0]    row,
	input  logic                          black,
	input  logic [rmfb_pkg::COLOR_W-1:0]  pixel_color,
	input  logic [rmfb_pkg::ADDR_W-1:0]   byte_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rmfb_pkg::BYTE_W-1:0]   frame_byte,
	output logic [rmfb_pkg::ADDR_W-1:0]   read_index
);
	import rmfb_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FILL   = 4'b0010,
		ST_MODIFY = 4'b0100,
		ST_READ   = 4'b1000
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	logic [BYTE_W-1:0] mem [STORE_BYTES];

	state_t              state_q;
	logic [ADDR_W-1:0]   fill_cnt_q;
	logic                fill_white_q;
	logic [LUMA_W-1:0]   thr_q;

	op_t                 op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [2:0]          bit_q;
	logic                black_q;
	logic                in_canvas_q;
	logic                idx_ok_q;
	logic [LUMA_W-1:0]   luma_q;
	logic [BYTE_W-1:0]   mem_rd_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   frame_byte_q;
	logic [ADDR_W-1:0]   read_index_q;

	logic                accept;
	op_t                 op_in;
	logic                in_canvas;
	logic                idx_ok;
	logic [ADDR_W-1:0]   plot_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [LUMA_W-1:0]   luma;
	logic                set_black;
	logic [BYTE_W-1:0]   mask;
	logic [BYTE_W-1:0]   new_byte;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [BYTE_W-1:0]   mem_wdata;

	rmfb_luma u_luma (
		.pixel_color (pixel_color),
		.luma        (luma)
	);

	// hold requests while busy, or while a result is waiting and not being taken
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign op_in    = op_t'(operation);

	assign in_canvas = (int'(col) < PANEL_COLS) && (int'(row) < PANEL_ROWS);
	assign idx_ok    = int'(byte_index) < STORE_BYTES;
	assign plot_addr = ADDR_W'(ADDR_W'(col) * ADDR_W'(STRIDE) + ADDR_W'(row >> 3));

	always_comb begin
		if (op_in == OP_READ) begin
			rd_addr = idx_ok ? byte_index : '0;
		end else begin
			rd_addr = in_canvas ? plot_addr : '0;
		end
	end

	assign set_black = (op_q == OP_PLOT_RGB) ? (luma_q < thr_q) : black_q;
	assign mask      = BIT_MSB >> bit_q;
	assign new_byte  = set_black ? (mem_rd_q & ~mask) : (mem_rd_q | mask);

	assign mem_we    = (state_q == ST_FILL) || ((state_q == ST_MODIFY) && in_canvas_q);
	assign mem_waddr = (state_q == ST_FILL) ? fill_cnt_q : addr_q;
	assign mem_wdata = (state_q == ST_FILL) ? (fill_white_q ? BYTE_WHITE : BYTE_BLACK)
		: new_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op_in;
			addr_q      <= plot_addr;
			bit_q       <= row[2:0];
			black_q     <= black;
			in_canvas_q <= in_canvas;
			idx_ok_q    <= idx_ok;
			luma_q      <= luma;
		end
		if (accept && op_in == OP_READ) begin
			read_index_q <= byte_index;
		end
		if (state_q == ST_READ) begin
			frame_byte_q <= idx_ok_q ? mem_rd_q : BYTE_BLACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			fill_cnt_q   <= '0;
			fill_white_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_READ) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op_in)
							OP_FILL: begin
								state_q      <= ST_FILL;
								fill_cnt_q   <= '0;
								fill_white_q <= !black;
							end
							OP_PLOT_MONO, OP_PLOT_RGB: state_q <= ST_MODIFY;
							OP_READ:                   state_q <= ST_READ;
							default:                   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FILL: begin
					// advance one byte a cycle, drop back to idle after the last
					if (fill_cnt_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						fill_cnt_q <= fill_cnt_q + 1'b1;
					end
				end
				ST_MODIFY: state_q <= ST_IDLE;
				ST_READ:   state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign read_index = read_index_q;

`ifndef NO_ASSERTIONS
	a_read_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("read result would overwrite a pending one");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_READ))
		else $error("result raised without a read");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (int'(mem_waddr) < STORE_BYTES))
		else $error("store write beyond last byte");

	a_fill_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) && (fill_cnt_q != LAST_ADDR) |=>
		(state_q == ST_FILL) && (fill_cnt_q == ADDR_W'($past(fill_cnt_q) + 1'b1)))
		else $error("fill sweep skipped or stopped early");

	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) && (fill_cnt_q == LAST_ADDR) |=> state_q == ST_IDLE)
		else $error("fill sweep ran past the store");
`endif

endmodule
